[rtl/fcst_pkg.sv]
package fcst_pkg;

    // tree geometry
    localparam int TREE_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(TREE_DEPTH);

    // field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 11;
    localparam int WGT_W  = 16;
    localparam int SIZE_W = 11;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;
    localparam int PROD_W = WGT_W + POS_W;

    // index wide enough for the depth, the position field and one upward step
    localparam int IDX_BASE_W = ($clog2(TREE_DEPTH + 1) > POS_W) ?
                                $clog2(TREE_DEPTH + 1) : POS_W;
    localparam int IDX_W      = IDX_BASE_W + 1;

    localparam logic [IDX_W-1:0]  DEPTH_IDX  = IDX_W'(TREE_DEPTH);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // datapath walk modes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_INIT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NOP   = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [WGT_W-1:0]  weight;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] prefix_count;
        logic [SUM_W-1:0] prefix_sum;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic run;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/fcst_ram.sv]
module fcst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fcst_ctrl.sv]
module fcst_ctrl
    import fcst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_dp_cmd    cmd;

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        unique case (r_state)
            S_INIT: begin
                cmd.run = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                cmd.run = 1'b1;
                if (i_sts.walk_done) begin
                    if (i_sts.out_free) begin
                        cmd.emit = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/fcst_dp.sv]
module fcst_dp
    import fcst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  t_in_item          i_in_item,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_out_item         o_out_item
);

    logic [SIZE_W-1:0] r_size;
    logic [MODE_W-1:0] r_mode;
    logic [IDX_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [WGT_W-1:0]  r_weight;
    logic [PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]  r_acc_cnt;
    logic [SUM_W-1:0]  r_acc_sum;
    logic              r_out_vld;
    t_out_item         r_out_item;

    logic [IDX_W-1:0]  size_ext;
    logic [IDX_W-1:0]  eff_n;
    logic [IDX_W-1:0]  pos_ext;
    logic [IDX_W-1:0]  low_bit;
    logic [IDX_W-1:0]  n_idx;
    logic [MODE_W-1:0] load_mode;
    logic              issue;
    logic              is_zero_wr;
    logic              is_read;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] idx_addr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [SUM_W-1:0]  sum_wdata;
    logic [CNT_W-1:0]  cnt_rdata;
    logic [SUM_W-1:0]  sum_rdata;
    logic              out_free;

    // effective tree size
    assign size_ext = IDX_W'(r_size);
    assign eff_n    = (size_ext > DEPTH_IDX) ? DEPTH_IDX : size_ext;
    assign pos_ext  = IDX_W'(i_in_item.position);

    // decode operation into walk mode
    always_comb begin
        unique case (i_in_item.func)
            FUNC_CLEAR: load_mode = MODE_CLEAR;
            FUNC_ADD:   load_mode = MODE_ADD;
            FUNC_QUERY: load_mode = MODE_QUERY;
            default:    load_mode = MODE_NOP;
        endcase
    end

    // node index walk
    assign low_bit  = r_idx & (~r_idx + IDX_W'(1));
    assign idx_addr = ADDR_W'(r_idx - IDX_W'(1));

    always_comb begin
        issue = 1'b0;
        n_idx = r_idx;
        unique case (r_mode)
            MODE_INIT: begin
                issue = (r_idx <= DEPTH_IDX);
                n_idx = r_idx + IDX_W'(1);
            end
            MODE_CLEAR: begin
                issue = (r_idx <= eff_n);
                n_idx = r_idx + IDX_W'(1);
            end
            MODE_ADD: begin
                issue = (r_idx != '0) && (r_idx <= eff_n);
                n_idx = r_idx + low_bit;
            end
            MODE_QUERY: begin
                issue = (r_idx != '0);
                n_idx = r_idx - low_bit;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign is_zero_wr = i_cmd.run && issue &&
                        ((r_mode == MODE_INIT) || (r_mode == MODE_CLEAR));
    assign is_read    = i_cmd.run && issue &&
                        ((r_mode == MODE_ADD) || (r_mode == MODE_QUERY));

    // write port: zero sweep or add write-back
    assign ram_we    = is_zero_wr || (r_rd_vld && (r_mode == MODE_ADD));
    assign ram_waddr = is_zero_wr ? idx_addr : r_rd_addr;
    assign cnt_wdata = is_zero_wr ? '0 : (cnt_rdata + CNT_W'(r_weight));
    assign sum_wdata = is_zero_wr ? '0 : (sum_rdata + SUM_W'(r_prod));

    fcst_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TREE_DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (idx_addr),
        .o_rdata (cnt_rdata)
    );

    fcst_ram #(
        .WIDTH (SUM_W),
        .DEPTH (TREE_DEPTH)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (idx_addr),
        .o_rdata (sum_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_RESET;
            r_mode    <= MODE_INIT;
            r_idx     <= IDX_W'(1);
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_mode <= load_mode;
                if ((load_mode == MODE_CLEAR) || (load_mode == MODE_INIT)) begin
                    r_idx <= IDX_W'(1);
                end else if (load_mode == MODE_QUERY) begin
                    r_idx <= (pos_ext > eff_n) ? eff_n : pos_ext;
                end else begin
                    r_idx <= pos_ext;
                end
            end else if (i_cmd.run && issue) begin
                r_idx <= n_idx;
            end
            r_rd_vld <= is_read;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_rd_addr <= idx_addr;
        end
        if (i_cmd.load) begin
            r_weight  <= i_in_item.weight;
            r_prod    <= PROD_W'(i_in_item.weight) * PROD_W'(i_in_item.position);
            r_acc_cnt <= '0;
            r_acc_sum <= '0;
        end else if (r_rd_vld && (r_mode == MODE_QUERY)) begin
            r_acc_cnt <= r_acc_cnt + cnt_rdata;
            r_acc_sum <= r_acc_sum + sum_rdata;
        end
        if (i_cmd.emit) begin
            r_out_item.prefix_count <= r_acc_cnt;
            r_out_item.prefix_sum   <= r_acc_sum;
        end
    end

    assign out_free        = !r_out_vld || !i_out_stall;
    assign o_sts.walk_done = !issue && !r_rd_vld;
    assign o_sts.out_free  = out_free;
    assign o_out_valid     = r_out_vld;
    assign o_out_item      = r_out_item;

endmodule

[rtl/fenwick_count_sum_tree_unit.sv]
// an add or query walks k lowbit nodes (k at most 11), a clear walks the n positions in use,
// and each result is stored in the output register once its walk ends and that register is free
// an item that reaches no node stores its result without a walk
// input: one item at a time; the next is taken only after a result is stored
// reset: synchronous, active low; then an init pass zeroes every node, input stalled
// tree_size returns to 1024 on reset
module fenwick_count_sum_tree_unit
    import fcst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    fcst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // node memories, walk and accumulation
    fcst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // a result is only moved into a free result register
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result emitted into an occupied register");

    // an accepted item sets the input stall
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // an emitted result shows on the output next cycle
    a_emit_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out_valid)
        else $error("emitted result not presented");

endmodule
